// ===== sv/pwht_pkg.sv =====
// Package with the constants, types and hash step of the position weld table.
`timescale 1ns / 1ps
package pwht_pkg;
    localparam int unsigned TABLE_SLOTS = 4096;
    localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
    localparam int unsigned COUNT_W = SLOT_W + 1;
    localparam int unsigned ID_W = 12;
    localparam int unsigned COORD_W = 64;
    localparam int unsigned KEY_BYTES = 24;
    localparam int unsigned BYTE_CNT_W = $clog2(KEY_BYTES);
    localparam logic [63:0] FNV_OFFSET = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

    localparam logic [1:0] STATUS_FOUND = 2'd0;
    localparam logic [1:0] STATUS_NEW = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic signed [COORD_W-1:0] coord_z;
    } key_t;

    typedef struct packed {
        logic [ID_W-1:0] vertex_id;
        logic [1:0] status;
    } result_t;

    // The prime has only bits 40, 8, 7, 5, 4, 1 and 0 set, so a multiply is a
    // sum of shifted copies.
    function automatic logic [63:0] fnv_mul(input logic [63:0] h);
        fnv_mul = h + (h << 1) + (h << 4) + (h << 5) + (h << 7) + (h << 8) + (h << 40);
    endfunction
endpackage

// ===== sv/pwht_if.sv =====
// Valid/ready channel interface for key and result items.
`timescale 1ns / 1ps
interface pwht_key_if (input logic clk);
    import pwht_pkg::*;
    logic valid;
    logic ready;
    key_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface pwht_result_if (input logic clk);
    import pwht_pkg::*;
    logic valid;
    logic ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pwht_hash.sv =====
// Byte-serial FNV-1a hash unit, one key byte per cycle.
`timescale 1ns / 1ps
module pwht_hash (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  pwht_pkg::key_t key,
    output logic done,
    output logic [63:0] hash
);
    import pwht_pkg::*;

    logic [63:0] hash_reg, hash_next;
    logic [8*KEY_BYTES-1:0] bytes_reg, bytes_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;
    logic done_reg, done_next;

    always_comb
    begin
        hash_next = hash_reg;
        bytes_next = bytes_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            hash_next = FNV_OFFSET;
            // x goes first, so it sits in the low bits of the shift register.
            bytes_next = {key.coord_z, key.coord_y, key.coord_x};
            cnt_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hash_next = fnv_mul(hash_reg ^ {56'd0, bytes_reg[7:0]});
            bytes_next = bytes_reg >> 8;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BYTE_CNT_W'(KEY_BYTES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= hash_next;
        bytes_reg <= bytes_next;
    end

    assign done = done_reg;
    assign hash = hash_reg;
endmodule

// ===== sv/position_weld_hash_table_core.sv =====
// Top level of the position weld deduplication table.
`timescale 1ns / 1ps
// Each key item is hashed with FNV-1a over its 24 bytes, one byte a cycle,
// and then probed linearly through a slot memory with a registered read,
// each probed slot taking a pass through ST_READ and ST_CHECK. The next key
// is taken once the item's result has moved into the result register. After
// reset a clearing pass walks the valid memory, one slot a cycle over all
// TABLE_SLOTS slots, before the first key is accepted.
// The result register lets the next key enter while a result waits.
module position_weld_hash_table_core (
    input logic clk,
    input logic rst_n,
    pwht_key_if.sink keys,
    pwht_result_if.source results
);
    import pwht_pkg::*;

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_READ  = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    typedef struct packed {
        key_t key;
        logic [ID_W-1:0] id;
    } entry_t;

    state_t state_reg, state_next;
    key_t key_reg;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [COUNT_W-1:0] probes_reg, probes_next;
    logic [COUNT_W-1:0] held_reg, held_next;
    result_t res_reg, res_next, pend_reg, pend_next;
    logic res_valid_reg, res_valid_next;

    // Slot memories: the valid bit apart, so the clearing pass writes only the valid bit of each slot.
    logic valid_mem [TABLE_SLOTS];
    entry_t entry_mem [TABLE_SLOTS];
    logic rd_valid;
    entry_t rd_entry;
    logic wr_en, vwr_en, vwr_data;
    logic [SLOT_W-1:0] wr_addr;

    logic hash_start, hash_done;
    logic [63:0] hash;

    pwht_hash u_hash (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .key(key_reg),
        .done(hash_done), .hash(hash)
    );

    assign keys.ready = (state_reg == ST_IDLE);
    assign results.valid = res_valid_reg;
    assign results.data = res_reg;

    always_ff @(posedge clk)
    begin
        rd_valid <= valid_mem[slot_next];
        rd_entry <= entry_mem[slot_next];
        if (vwr_en)
            valid_mem[wr_addr] <= vwr_data;
        if (wr_en)
            entry_mem[wr_addr] <= '{key: key_reg, id: held_reg[ID_W-1:0]};
        if (keys.valid && keys.ready)
            key_reg <= keys.data;
    end

    logic hit;
    assign hit = (rd_entry.key == key_reg);

    always_comb
    begin
        state_next = state_reg;
        slot_next = slot_reg;
        probes_next = probes_reg;
        held_next = held_reg;
        res_next = res_reg;
        pend_next = pend_reg;
        res_valid_next = res_valid_reg;
        hash_start = 1'b0;
        wr_en = 1'b0;
        vwr_en = 1'b0;
        vwr_data = 1'b0;
        wr_addr = slot_reg;
        if (results.ready)
            res_valid_next = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                vwr_en = 1'b1;
                slot_next = slot_reg + 1'b1;
                if (slot_reg == SLOT_W'(TABLE_SLOTS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (keys.valid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (!hash_done && probes_reg == '0)
                begin
                    hash_start = 1'b1;
                    probes_next = COUNT_W'(1);
                end
                if (hash_done)
                begin
                    slot_next = hash[SLOT_W-1:0];
                    probes_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = ST_OUT;
                if (!rd_valid)
                begin
                    wr_en = 1'b1;
                    vwr_en = 1'b1;
                    vwr_data = 1'b1;
                    pend_next = '{vertex_id: held_reg[ID_W-1:0], status: STATUS_NEW};
                    if (held_reg < COUNT_W'(TABLE_SLOTS))
                        held_next = held_reg + 1'b1;
                end
                else if (hit)
                begin
                    pend_next = '{vertex_id: rd_entry.id, status: STATUS_FOUND};
                end
                else if (probes_reg == COUNT_W'(TABLE_SLOTS - 1))
                begin
                    pend_next = '{vertex_id: '0, status: STATUS_FULL};
                end
                else
                begin
                    probes_next = probes_reg + 1'b1;
                    slot_next = slot_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_OUT:
            begin
                if (!res_valid_reg || results.ready)
                begin
                    res_next = pend_reg;
                    res_valid_next = 1'b1;
                    probes_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            slot_reg <= '0;
            probes_reg <= '0;
            held_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg <= slot_next;
            probes_reg <= probes_next;
            held_reg <= held_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        pend_reg <= pend_next;
    end

`ifndef ASSERT_OFF
    a_no_key_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !keys.ready)
        else $error("key accepted while busy");
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= COUNT_W'(TABLE_SLOTS))
        else $error("entry count overflow");
    a_full_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.data.status == STATUS_FULL) |->
        results.data.vertex_id == '0)
        else $error("full result with nonzero id");
    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !rd_valid && held_reg < COUNT_W'(TABLE_SLOTS))
        |=> held_reg == $past(held_reg) + 1'b1)
        else $error("insert did not advance count");
`endif
endmodule

// ===== dv/pwht_weld_checker.sv =====
// Checker that predicts the vertex index of each key item and compares results.
`timescale 1ns / 1ps
module pwht_weld_checker (
    input logic clk,
    input logic rst_n,
    pwht_key_if.sink keys,
    pwht_result_if.sink results,
    output int unsigned mismatches,
    output int unsigned pending,
    output int unsigned found_cnt,
    output int unsigned new_cnt,
    output int unsigned full_cnt
);
    import pwht_pkg::*;

    bit table_used [TABLE_SLOTS];
    key_t table_key [TABLE_SLOTS];
    logic [ID_W-1:0] table_id [TABLE_SLOTS];
    int unsigned keys_stored;
    result_t expected_ids [$];

    function automatic logic [63:0] fold_word(logic [63:0] h, logic [63:0] w);
        for (int b = 0; b < 8; b++)
        begin
            h = h ^ {56'd0, w[8*b +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // Walks the shadow table exactly as the block should and updates it.
    function automatic result_t weld_lookup(key_t k);
        logic [63:0] h;
        int unsigned slot;
        result_t r;
        h = fold_word(FNV_OFFSET, k.coord_x);
        h = fold_word(h, k.coord_y);
        h = fold_word(h, k.coord_z);
        slot = 32'(h % TABLE_SLOTS);
        for (int p = 0; p < TABLE_SLOTS; p++)
        begin
            if (!table_used[slot])
            begin
                r.vertex_id = keys_stored[ID_W-1:0];
                r.status = STATUS_NEW;
                table_used[slot] = 1'b1;
                table_key[slot] = k;
                table_id[slot] = r.vertex_id;
                if (keys_stored < TABLE_SLOTS)
                    keys_stored++;
                return r;
            end
            if (table_key[slot] == k)
            begin
                r.vertex_id = table_id[slot];
                r.status = STATUS_FOUND;
                return r;
            end
            slot = (slot + 1) % TABLE_SLOTS;
        end
        r.vertex_id = '0;
        r.status = STATUS_FULL;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            foreach (table_used[i])
                table_used[i] = 1'b0;
            keys_stored = 0;
            expected_ids.delete();
            mismatches <= 0;
            pending <= 0;
            found_cnt <= 0;
            new_cnt <= 0;
            full_cnt <= 0;
        end
        else
        begin
            if (keys.valid && keys.ready)
                expected_ids = {expected_ids, weld_lookup(keys.data)};
            if (results.valid && results.ready)
            begin
                if (results.data.status == STATUS_FOUND) found_cnt <= found_cnt + 1;
                if (results.data.status == STATUS_NEW) new_cnt <= new_cnt + 1;
                if (results.data.status == STATUS_FULL) full_cnt <= full_cnt + 1;
                if (expected_ids.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result id=%0d st=%0d", $realtime,
                                 results.data.vertex_id, results.data.status);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_r = expected_ids.pop_front();
                    if (exp_r.vertex_id !== results.data.vertex_id
                        || exp_r.status !== results.data.status)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch id exp %0d got %0d, status exp %0d got %0d",
                                     $realtime, exp_r.vertex_id, results.data.vertex_id,
                                     exp_r.status, results.data.status);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            pending <= expected_ids.size();
        end
    end
endmodule

// ===== dv/tb.sv =====
// Testbench top: drives key items and gives the verdict.
`timescale 1ns / 1ps
module tb;
    import pwht_pkg::*;

    logic clk;
    logic rst_n;
    int unsigned mismatches, pending, found_cnt, new_cnt, full_cnt;
    bit calm;
    bit hold_off;
    key_t seen_keys [$];
    int unsigned sent;

    pwht_key_if keys (clk);
    pwht_result_if results (clk);

    position_weld_hash_table_core DUT (.clk(clk), .rst_n(rst_n), .keys(keys), .results(results));

    pwht_weld_checker checker_i (.clk(clk), .rst_n(rst_n), .keys(keys), .results(results),
        .mismatches(mismatches), .pending(pending), .found_cnt(found_cnt),
        .new_cnt(new_cnt), .full_cnt(full_cnt));

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("timeout");
        $display("status: fail");
        $finish;
    end

    function automatic logic [63:0] edge_word();
        case ($urandom_range(0, 5))
            0: return 64'h8000000000000000;
            1: return 64'h7FFFFFFFFFFFFFFF;
            2: return 64'hFFFFFFFFFFFFFFFF;
            3: return 64'd0;
            4: return {$urandom, $urandom};
            default: return $urandom_range(0, 3) - 64'sd1;
        endcase
    endfunction

    function automatic key_t fresh_key();
        key_t k;
        if ($urandom_range(0, 3) == 0)
        begin
            k.coord_x = edge_word();
            k.coord_y = edge_word();
            k.coord_z = edge_word();
        end
        else
        begin
            k.coord_x = {$urandom, $urandom};
            k.coord_y = {$urandom, $urandom};
            k.coord_z = {$urandom, $urandom};
        end
        return k;
    endfunction

    // Offers one key item, with a random gap first unless the run is calm.
    // Valid stays high after acceptance so that back-to-back items need no gap.
    task automatic send_key(key_t k);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            keys.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        keys.valid <= 1'b1;
        keys.data <= k;
        @(posedge clk);
        while (!keys.ready)
            @(posedge clk);
        seen_keys = {seen_keys, k};
        sent++;
    endtask

    // Receiver: random stall bursts, one long hold-off, none when calm.
    initial
    begin
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                results.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 13) - 1) @(posedge clk);
            end
            else
                results.ready <= 1'b1;
        end
    end

    initial
    begin
        key_t k;
        int unsigned wait_cnt;
        keys.valid = 1'b0;
        keys.data = '0;
        calm = 1'b0;
        hold_off = 1'b0;
        sent = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme coordinates, repeats, and a near-miss key.
        k = '0;
        send_key(k);
        send_key(k);
        k.coord_x = 64'h8000000000000000; k.coord_y = 64'h7FFFFFFFFFFFFFFF; k.coord_z = '1;
        send_key(k);
        k.coord_z = 64'hFFFFFFFFFFFFFFFE;
        send_key(k);
        k = '1;
        send_key(k);
        send_key(k);
        k = '0; k.coord_z = 64'd1;
        send_key(k);
        k = '0; k.coord_x = 64'h0100000000000000;
        send_key(k);
        for (int i = 0; i < 8; i++)
            send_key(seen_keys[$urandom_range(0, seen_keys.size() - 1)]);

        hold_off = 1'b1;
        for (int i = 0; i < 1880; i++)
        begin
            if (i == 1700)
                calm = 1'b1;
            if ($urandom_range(0, 2) == 0)
                send_key(seen_keys[$urandom_range(0, seen_keys.size() - 1)]);
            else
                send_key(fresh_key());
        end
        keys.valid <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 200000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (100) @(posedge clk);
        $display("Sent %0d keys; results: %0d found, %0d new, %0d full.",
                 sent, found_cnt, new_cnt, full_cnt);
        $display("Covered extreme coordinates, repeated keys, near misses and stalls.");
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
